[rtl/lfu_pkg.sv]
// shared types and constants for the lfu cache with lru tie break
// no dependencies; used by the cache top level

package lfu_pkg;

    localparam int KEY_BITS    = 16;
    localparam int VALUE_BITS  = 32;
    localparam int COUNT_W     = 16;
    localparam int CAP_W       = 5;
    localparam int ENTRIES_DEF = 16;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [CAP_W-1:0]   CAP_RESET = CAP_W'(16);

    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PLAN,
        ST_SWEEP,
        ST_COMMIT,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic                         operation;
        logic [KEY_BITS-1:0]          key;
        logic signed [VALUE_BITS-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic                         hit;
        logic signed [VALUE_BITS-1:0] read_value;
    } t_out_item;

endpackage

[rtl/lfu_cache_lru_tiebreak_unit.sv]
// top level of the fully associative lfu cache with lru tie break
// depends on lfu_pkg and lfu_ram

// Fully associative key/value cache with least-frequently-used replacement; among entries
// of equal use count the least recently touched one is evicted. A get returns the stored
// value and a hit flag; a put updates a present key or inserts a new one with count one,
// evicting first when occupancy has reached the capacity register (capped at ENTRIES;
// zero makes puts do nothing). Keys, values, counts and recency ranks live in single
// read port rams that are walked one entry per cycle. Each item gets a match/victim
// scan over all entries; unless nothing is updated (get miss, put with capacity zero)
// a rank update pass over the rank ram and a commit follow, and no new item is taken
// before the item is done. The result sits in an output register, so a new item is
// taken while the previous result waits. No clearing pass follows reset.

module lfu_cache_lru_tiebreak_unit #(
    parameter int ENTRIES = lfu_pkg::ENTRIES_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  lfu_pkg::t_in_item        i_in_data,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output lfu_pkg::t_out_item       o_out_data,
    input  logic                     i_cfg_we,
    input  logic [lfu_pkg::CAP_W-1:0] i_cfg_data
);

    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int RANK_W = IDX_W;
    localparam int KW     = lfu_pkg::KEY_BITS;
    localparam int VW     = lfu_pkg::VALUE_BITS;
    localparam int CW     = lfu_pkg::COUNT_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    lfu_pkg::t_state r_state, n_state;

    logic [lfu_pkg::CAP_W-1:0] r_capacity;

    logic          r_op, n_op;
    logic [KW-1:0] r_key, n_key;
    logic [VW-1:0] r_value, n_value;

    logic [CNT_W-1:0] r_idx, n_idx;
    logic             r_pvld, n_pvld;
    logic [IDX_W-1:0] r_pidx, n_pidx;

    logic              r_found, n_found;
    logic [IDX_W-1:0]  r_found_idx, n_found_idx;
    logic [RANK_W-1:0] r_found_rank, n_found_rank;
    logic [CW-1:0]     r_found_cnt, n_found_cnt;
    logic [VW-1:0]     r_found_val, n_found_val;

    logic              r_vic_have, n_vic_have;
    logic [IDX_W-1:0]  r_vic_idx, n_vic_idx;
    logic [CW-1:0]     r_vic_cnt, n_vic_cnt;
    logic [RANK_W-1:0] r_vic_rank, n_vic_rank;

    logic             r_free_have, n_free_have;
    logic [IDX_W-1:0] r_free_idx, n_free_idx;

    logic             r_do_touch, n_do_touch;
    logic             r_do_insert, n_do_insert;
    logic             r_do_evict, n_do_evict;
    logic [IDX_W-1:0] r_target, n_target;

    logic          r_hit, n_hit;
    logic [VW-1:0] r_rdval, n_rdval;

    logic [ENTRIES-1:0] r_valid, n_valid;
    logic [CNT_W-1:0]   r_occ, n_occ;

    logic               r_out_valid, n_out_valid;
    lfu_pkg::t_out_item r_out_data, n_out_data;

    // ram ports
    logic [IDX_W-1:0]  w_raddr;
    logic [KW-1:0]     w_key_rd;
    logic [VW-1:0]     w_val_rd;
    logic [CW-1:0]     w_cnt_rd;
    logic [RANK_W-1:0] w_rank_rd;
    logic              w_key_we, w_val_we, w_cnt_we, w_rank_we;
    logic [CW-1:0]     w_cnt_wdata;
    logic [RANK_W-1:0] w_rank_wdata;

    // plan decoded from scan results
    logic [CNT_W-1:0] w_cap;
    logic             w_cap_zero, w_is_put, w_touch, w_miss_put, w_evict;
    logic             w_use_vic, w_insert;
    logic [IDX_W-1:0] w_slot, w_target;

    logic w_accept, w_issue, w_ent_valid, w_out_free;

    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_raddr    = r_idx[IDX_W-1:0];
    assign w_issue    = (r_idx < CNT_W'(ENTRIES));
    assign w_ent_valid = r_valid[r_pidx];
    assign w_out_free = !r_out_valid || !i_out_stall;

    assign w_cap      = (32'(r_capacity) > 32'(ENTRIES)) ? CNT_W'(ENTRIES)
                                                          : CNT_W'(r_capacity);
    assign w_cap_zero = (w_cap == '0);
    assign w_is_put   = (r_op == lfu_pkg::OP_PUT);
    assign w_touch    = r_found && (!w_is_put || !w_cap_zero);
    assign w_miss_put = !r_found && w_is_put && !w_cap_zero;
    assign w_evict    = w_miss_put && (r_occ >= w_cap) && r_vic_have;
    assign w_use_vic  = w_evict && (!r_free_have || (r_vic_idx < r_free_idx));
    assign w_slot     = w_use_vic ? r_vic_idx : r_free_idx;
    assign w_insert   = w_miss_put && (w_evict || r_free_have);
    assign w_target   = w_touch ? r_found_idx : w_slot;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            lfu_pkg::ST_IDLE: begin
                if (w_accept) n_state = lfu_pkg::ST_SCAN;
            end
            lfu_pkg::ST_SCAN: begin
                if (r_pvld && (r_pidx == LAST_IDX)) n_state = lfu_pkg::ST_PLAN;
            end
            lfu_pkg::ST_PLAN: begin
                n_state = (w_touch || w_insert) ? lfu_pkg::ST_SWEEP : lfu_pkg::ST_DONE;
            end
            lfu_pkg::ST_SWEEP: begin
                if (r_pvld && (r_pidx == LAST_IDX)) n_state = lfu_pkg::ST_COMMIT;
            end
            lfu_pkg::ST_COMMIT: begin
                n_state = lfu_pkg::ST_DONE;
            end
            lfu_pkg::ST_DONE: begin
                if (w_out_free) n_state = lfu_pkg::ST_IDLE;
            end
            default: n_state = lfu_pkg::ST_IDLE;
        endcase
    end

    // datapath and output control
    always_comb begin
        n_op         = r_op;
        n_key        = r_key;
        n_value      = r_value;
        n_idx        = r_idx;
        n_pvld       = 1'b0;
        n_pidx       = r_pidx;
        n_found      = r_found;
        n_found_idx  = r_found_idx;
        n_found_rank = r_found_rank;
        n_found_cnt  = r_found_cnt;
        n_found_val  = r_found_val;
        n_vic_have   = r_vic_have;
        n_vic_idx    = r_vic_idx;
        n_vic_cnt    = r_vic_cnt;
        n_vic_rank   = r_vic_rank;
        n_free_have  = r_free_have;
        n_free_idx   = r_free_idx;
        n_do_touch   = r_do_touch;
        n_do_insert  = r_do_insert;
        n_do_evict   = r_do_evict;
        n_target     = r_target;
        n_hit        = r_hit;
        n_rdval      = r_rdval;
        n_valid      = r_valid;
        n_occ        = r_occ;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_data   = r_out_data;
        w_key_we     = 1'b0;
        w_val_we     = 1'b0;
        w_cnt_we     = 1'b0;
        w_cnt_wdata  = r_found_cnt;
        w_rank_we    = 1'b0;
        w_rank_wdata = w_rank_rd;

        case (r_state)
            lfu_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_op        = i_in_data.operation;
                    n_key       = i_in_data.key;
                    n_value     = i_in_data.value;
                    n_idx       = '0;
                    n_found     = 1'b0;
                    n_vic_have  = 1'b0;
                    n_free_have = 1'b0;
                end
            end
            lfu_pkg::ST_SCAN: begin
                if (w_issue) begin
                    n_pvld = 1'b1;
                    n_pidx = r_idx[IDX_W-1:0];
                    n_idx  = r_idx + CNT_W'(1);
                end
                if (r_pvld) begin
                    if (w_ent_valid && (w_key_rd == r_key) && !r_found) begin
                        n_found      = 1'b1;
                        n_found_idx  = r_pidx;
                        n_found_rank = w_rank_rd;
                        n_found_cnt  = w_cnt_rd;
                        n_found_val  = w_val_rd;
                    end
                    // lowest count wins, the oldest rank among equal counts
                    if (w_ent_valid && (!r_vic_have || (w_cnt_rd < r_vic_cnt) ||
                        ((w_cnt_rd == r_vic_cnt) && (w_rank_rd > r_vic_rank)))) begin
                        n_vic_have = 1'b1;
                        n_vic_idx  = r_pidx;
                        n_vic_cnt  = w_cnt_rd;
                        n_vic_rank = w_rank_rd;
                    end
                    if (!w_ent_valid && !r_free_have) begin
                        n_free_have = 1'b1;
                        n_free_idx  = r_pidx;
                    end
                end
            end
            lfu_pkg::ST_PLAN: begin
                n_do_touch  = w_touch;
                n_do_insert = w_insert;
                n_do_evict  = w_evict;
                n_target    = w_target;
                n_hit       = r_found;
                n_rdval     = (!w_is_put && r_found) ? r_found_val : '0;
                n_idx       = '0;
            end
            lfu_pkg::ST_SWEEP: begin
                if (w_issue) begin
                    n_pvld = 1'b1;
                    n_pidx = r_idx[IDX_W-1:0];
                    n_idx  = r_idx + CNT_W'(1);
                end
                if (r_pvld) begin
                    w_rank_wdata = w_rank_rd + RANK_W'(1);
                    if (r_pidx == r_target) begin
                        w_rank_we    = 1'b1;
                        w_rank_wdata = '0;
                    end else if (w_ent_valid) begin
                        if (r_do_touch) begin
                            w_rank_we = (w_rank_rd < r_found_rank);
                        end else begin
                            // eviction closes the gap, insertion opens rank zero
                            w_rank_we = !(r_do_evict && ((r_pidx == r_vic_idx) ||
                                                         (w_rank_rd > r_vic_rank)));
                        end
                    end
                end
            end
            lfu_pkg::ST_COMMIT: begin
                w_key_we = r_do_insert;
                w_val_we = w_is_put;
                w_cnt_we = 1'b1;
                if (r_do_insert) begin
                    w_cnt_wdata = CW'(1);
                end else if (r_found_cnt != lfu_pkg::COUNT_MAX) begin
                    w_cnt_wdata = r_found_cnt + CW'(1);
                end
                if (r_do_evict && (r_vic_idx != r_target)) begin
                    n_valid[r_vic_idx] = 1'b0;
                end
                if (r_do_insert) begin
                    n_valid[r_target] = 1'b1;
                    if (!r_do_evict) n_occ = r_occ + CNT_W'(1);
                end
            end
            lfu_pkg::ST_DONE: begin
                if (w_out_free) begin
                    n_out_valid           = 1'b1;
                    n_out_data.hit        = r_hit;
                    n_out_data.read_value = r_rdval;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lfu_pkg::ST_IDLE;
            r_capacity  <= lfu_pkg::CAP_RESET;
            r_pvld      <= 1'b0;
            r_valid     <= '0;
            r_occ       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            if (i_cfg_we) r_capacity <= i_cfg_data;
            r_pvld      <= n_pvld;
            r_valid     <= n_valid;
            r_occ       <= n_occ;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_key        <= n_key;
        r_value      <= n_value;
        r_idx        <= n_idx;
        r_pidx       <= n_pidx;
        r_found      <= n_found;
        r_found_idx  <= n_found_idx;
        r_found_rank <= n_found_rank;
        r_found_cnt  <= n_found_cnt;
        r_found_val  <= n_found_val;
        r_vic_have   <= n_vic_have;
        r_vic_idx    <= n_vic_idx;
        r_vic_cnt    <= n_vic_cnt;
        r_vic_rank   <= n_vic_rank;
        r_free_have  <= n_free_have;
        r_free_idx   <= n_free_idx;
        r_do_touch   <= n_do_touch;
        r_do_insert  <= n_do_insert;
        r_do_evict   <= n_do_evict;
        r_target     <= n_target;
        r_hit        <= n_hit;
        r_rdval      <= n_rdval;
        r_out_data   <= n_out_data;
    end

    assign o_in_stall  = (r_state != lfu_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    lfu_ram #(.WIDTH(KW), .DEPTH(ENTRIES)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (w_key_we),
        .i_waddr (r_target),
        .i_wdata (r_key),
        .i_raddr (w_raddr),
        .o_rdata (w_key_rd)
    );

    lfu_ram #(.WIDTH(VW), .DEPTH(ENTRIES)) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (w_val_we),
        .i_waddr (r_target),
        .i_wdata (r_value),
        .i_raddr (w_raddr),
        .o_rdata (w_val_rd)
    );

    lfu_ram #(.WIDTH(CW), .DEPTH(ENTRIES)) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (w_cnt_we),
        .i_waddr (r_target),
        .i_wdata (w_cnt_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_cnt_rd)
    );

    lfu_ram #(.WIDTH(RANK_W), .DEPTH(ENTRIES)) u_rank_ram (
        .i_clk   (i_clk),
        .i_we    (w_rank_we),
        .i_waddr (r_pidx),
        .i_wdata (w_rank_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rank_rd)
    );

`ifndef SYNTHESIS
    a_occ_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == 32'(r_occ))
        else $error("occupancy count disagrees with valid bits");

    a_touch_target_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lfu_pkg::ST_SWEEP && r_do_touch) |-> r_valid[r_target])
        else $error("touch on an entry that is not valid");

    a_insert_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lfu_pkg::ST_COMMIT && r_do_insert && !r_do_evict)
            |-> !r_valid[r_target])
        else $error("insert into an occupied entry");

    a_accept_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == lfu_pkg::ST_SCAN && !r_found))
        else $error("transfer did not start a scan");
`endif

endmodule

[rtl/lfu_ram.sv]
// generic simple dual port ram: one write port, one registered read port
// no dependencies

module lfu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[tb/sv/lfu_cache_lru_tiebreak_unit_test.sv]
// self-checking testbench for the lfu cache with lru tie break: directed table, then random
// phases across several capacities; depends on lfu_pkg and lfu_cache_lru_tiebreak_unit

`timescale 1ns / 1ps

module lfu_cache_lru_tiebreak_unit_test;

    localparam int ENTRIES         = lfu_pkg::ENTRIES_DEF;
    localparam int CLK_PERIOD      = 10;
    localparam int RESET_CYCLES    = 8;
    localparam int SETTLE_CYCLES   = 2 * ENTRIES + 6;
    localparam int LONG_HOLD       = 400;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int PHASES          = 8;
    localparam int PHASE_ITEMS     = 140;
    localparam int PRESSURE_PHASE  = 6;
    localparam int KEY_POOL        = 24;

    typedef enum logic {ROW_ACCESS, ROW_CAPACITY} t_row_kind;

    typedef struct {
        t_row_kind                 kind;
        logic [lfu_pkg::CAP_W-1:0] cap;
        lfu_pkg::t_in_item         item;
        bit                        typed;
        lfu_pkg::t_out_item        want;
    } t_row;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_stall;
    lfu_pkg::t_in_item         in_data;
    logic                      out_valid;
    logic                      out_stall;
    lfu_pkg::t_out_item        out_data;
    logic                      cfg_we;
    logic [lfu_pkg::CAP_W-1:0] cfg_data;

    // cache shadow used to predict every lookup
    logic                           ent_valid [ENTRIES];
    logic [lfu_pkg::KEY_BITS-1:0]   ent_key   [ENTRIES];
    logic [lfu_pkg::VALUE_BITS-1:0] ent_value [ENTRIES];
    logic [lfu_pkg::COUNT_W-1:0]    ent_count [ENTRIES];
    int unsigned                    ent_rank  [ENTRIES];
    int unsigned                    occupied;
    logic [lfu_pkg::CAP_W-1:0]      cache_cap;

    lfu_pkg::t_out_item             pending_results [$];
    t_row                           script [$];
    logic [lfu_pkg::KEY_BITS-1:0]   key_pool [KEY_POOL];

    bit                 row_typed;
    lfu_pkg::t_out_item row_want;
    int                 mismatches;
    int                 burst_left;
    int                 hold_seq;
    int                 hold_seen;
    int                 hold_left;
    int                 seg_left;
    int                 stall_mode;
    int                 idle_cycles;

    lfu_cache_lru_tiebreak_unit uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    initial begin
        for (int i = 0; i < ENTRIES; i++) begin
            ent_valid[i] = 1'b0;
            ent_key[i]   = '0;
            ent_value[i] = '0;
            ent_count[i] = '0;
            ent_rank[i]  = 0;
        end
        occupied    = 0;
        cache_cap   = lfu_pkg::CAP_RESET;
        mismatches  = 0;
        burst_left  = 0;
        hold_seen   = 0;
        hold_left   = 0;
        seg_left    = 0;
        stall_mode  = 0;
        idle_cycles = 0;
    end

    // make entry e the most recent, count saturates
    function automatic void touch_entry(input int e);
        for (int i = 0; i < ENTRIES; i++)
            if (ent_valid[i] && ent_rank[i] < ent_rank[e])
                ent_rank[i]++;
        ent_rank[e] = 0;
        if (ent_count[e] != lfu_pkg::COUNT_MAX)
            ent_count[e]++;
    endfunction

    function automatic lfu_pkg::t_out_item predict_access(input lfu_pkg::t_in_item it);
        int                 found;
        int                 victim;
        int                 slot;
        int unsigned        eff_cap;
        int unsigned        gone_rank;
        lfu_pkg::t_out_item res;
        found   = -1;
        victim  = -1;
        slot    = -1;
        eff_cap = (cache_cap > ENTRIES) ? ENTRIES : cache_cap;
        for (int i = 0; i < ENTRIES; i++)
            if (found < 0 && ent_valid[i] && ent_key[i] == it.key)
                found = i;
        res.hit        = (found >= 0);
        res.read_value = '0;
        if (it.operation == lfu_pkg::OP_GET) begin
            if (found >= 0) begin
                res.read_value = ent_value[found];
                touch_entry(found);
            end
        end else if (eff_cap != 0) begin
            if (found >= 0) begin
                ent_value[found] = it.value;
                touch_entry(found);
            end else begin
                if (occupied >= eff_cap) begin
                    // lowest count first, oldest among equals
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (!ent_valid[i])
                            continue;
                        if (victim < 0 || ent_count[i] < ent_count[victim] ||
                            (ent_count[i] == ent_count[victim] &&
                             ent_rank[i] > ent_rank[victim]))
                            victim = i;
                    end
                    if (victim >= 0) begin
                        gone_rank = ent_rank[victim];
                        ent_valid[victim] = 1'b0;
                        for (int i = 0; i < ENTRIES; i++)
                            if (ent_valid[i] && ent_rank[i] > gone_rank)
                                ent_rank[i]--;
                        if (occupied > 0)
                            occupied--;
                    end
                end
                for (int i = 0; i < ENTRIES; i++)
                    if (slot < 0 && !ent_valid[i])
                        slot = i;
                if (slot >= 0) begin
                    for (int i = 0; i < ENTRIES; i++)
                        if (ent_valid[i])
                            ent_rank[i]++;
                    ent_valid[slot] = 1'b1;
                    ent_key[slot]   = it.key;
                    ent_value[slot] = it.value;
                    ent_count[slot] = lfu_pkg::COUNT_W'(1);
                    ent_rank[slot]  = 0;
                    occupied++;
                end
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        $display("mismatch %0d at %0t: %s got %h expected %h", mismatches, $realtime,
                 what, got, want);
    endtask

    function automatic void add_access(input logic op,
                                       input logic [lfu_pkg::KEY_BITS-1:0] key,
                                       input logic [lfu_pkg::VALUE_BITS-1:0] val,
                                       input bit typed, input logic hit,
                                       input logic [lfu_pkg::VALUE_BITS-1:0] rv);
        t_row r;
        r.kind            = ROW_ACCESS;
        r.cap             = '0;
        r.item.operation  = op;
        r.item.key        = key;
        r.item.value      = val;
        r.typed           = typed;
        r.want.hit        = hit;
        r.want.read_value = rv;
        script.push_back(r);
    endfunction

    function automatic void add_capacity(input logic [lfu_pkg::CAP_W-1:0] cap);
        t_row r;
        r.kind  = ROW_CAPACITY;
        r.cap   = cap;
        r.item  = '0;
        r.typed = 1'b0;
        r.want  = '0;
        script.push_back(r);
    endfunction

    task automatic send_access(input lfu_pkg::t_in_item it, input bit typed,
                               input lfu_pkg::t_out_item want);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 45);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_valid  <= 1'b1;
        in_data   <= it;
        row_typed <= typed;
        row_want  <= want;
        do @(posedge clk); while (in_stall);
        burst_left--;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [lfu_pkg::CAP_W-1:0] cap);
        wait_drained();
        cfg_we   <= 1'b1;
        cfg_data <= cap;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    // transfer tracking: expectations in, results checked in order
    always @(posedge clk) begin : track
        lfu_pkg::t_out_item predicted;
        lfu_pkg::t_out_item expected;
        if (rst_n) begin
            if (in_valid && !in_stall) begin
                predicted = predict_access(in_data);
                pending_results.push_back(row_typed ? row_want : predicted);
            end
            if (out_valid && !out_stall) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("result with nothing pending", out_data.read_value, '0);
                end else begin
                    expected = pending_results.pop_front();
                    if (out_data.hit !== expected.hit)
                        report_mismatch("hit", 32'(out_data.hit), 32'(expected.hit));
                    if (out_data.read_value !== expected.read_value)
                        report_mismatch("read_value", out_data.read_value,
                                        expected.read_value);
                end
            end
            if (cfg_we)
                cache_cap = cfg_data;
        end
    end

    // receiver: segments of free flow, light and heavy stalling, plus one long hold
    always @(posedge clk) begin
        if (hold_seq != hold_seen) begin
            hold_seen = hold_seq;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else begin
            if (seg_left == 0) begin
                seg_left   = $urandom_range(5, 80);
                stall_mode = $urandom_range(0, 2);
            end
            seg_left--;
            case (stall_mode)
                0: begin
                    out_stall <= 1'b0;
                end
                1: begin
                    out_stall <= ($urandom_range(0, 3) == 0);
                end
                default: begin
                    out_stall <= ($urandom_range(0, 3) != 0);
                end
            endcase
        end
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        logic [lfu_pkg::CAP_W-1:0] phase_caps [PHASES];
        lfu_pkg::t_in_item         item;
        lfu_pkg::t_out_item        none;
        int unsigned               eff_cap;
        int                        win;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        out_stall <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_data  <= '0;
        row_typed <= 1'b0;
        row_want  <= '0;
        hold_seq  <= 0;
        none      = '0;

        phase_caps = '{5'd16, 5'd1, 5'd31, 5'd3, 5'd0, 5'd8, 5'd16, 5'd2};
        for (int i = 0; i < KEY_POOL; i++)
            key_pool[i] = lfu_pkg::KEY_BITS'($urandom);

        // empty cache, key and value extremes
        add_access(lfu_pkg::OP_GET, 16'h0000, 32'h5A5A5A5A, 1'b1, 1'b0, 32'h0);
        add_access(lfu_pkg::OP_GET, 16'hFFFF, 32'hA5A5A5A5, 1'b1, 1'b0, 32'h0);
        add_access(lfu_pkg::OP_PUT, 16'h0000, 32'h7FFFFFFF, 1'b1, 1'b0, 32'h0);
        add_access(lfu_pkg::OP_PUT, 16'hFFFF, 32'h80000000, 1'b1, 1'b0, 32'h0);
        add_access(lfu_pkg::OP_GET, 16'h0000, 32'hFFFFFFFF, 1'b1, 1'b1, 32'h7FFFFFFF);
        add_access(lfu_pkg::OP_GET, 16'hFFFF, 32'h00000000, 1'b1, 1'b1, 32'h80000000);
        add_access(lfu_pkg::OP_PUT, 16'h0000, 32'hFFFFFFFF, 1'b1, 1'b1, 32'h0);
        add_access(lfu_pkg::OP_GET, 16'h0000, 32'h12345678, 1'b1, 1'b1, 32'hFFFFFFFF);
        add_access(lfu_pkg::OP_PUT, 16'h1234, 32'h00000005, 1'b1, 1'b0, 32'h0);
        add_access(lfu_pkg::OP_PUT, 16'h00A5, 32'h00000006, 1'b1, 1'b0, 32'h0);
        // capacity below occupancy: evict then insert, occupancy holds
        add_capacity(5'd2);
        add_access(lfu_pkg::OP_PUT, 16'h0042, 32'hDEADBEEF, 1'b1, 1'b0, 32'h0);
        add_access(lfu_pkg::OP_GET, 16'h1234, 32'h0, 1'b0, 1'b0, 32'h0);
        add_access(lfu_pkg::OP_GET, 16'h00A5, 32'h0, 1'b0, 1'b0, 32'h0);
        add_access(lfu_pkg::OP_PUT, 16'h0077, 32'h00000077, 1'b0, 1'b0, 32'h0);
        // capacity zero: puts ignored, lookups still work
        add_capacity(5'd0);
        add_access(lfu_pkg::OP_PUT, 16'h0500, 32'h00000500, 1'b1, 1'b0, 32'h0);
        add_access(lfu_pkg::OP_GET, 16'h0500, 32'h0, 1'b1, 1'b0, 32'h0);
        add_access(lfu_pkg::OP_PUT, 16'h0000, 32'h0000000B, 1'b1, 1'b1, 32'h0);
        add_access(lfu_pkg::OP_GET, 16'h0000, 32'h0, 1'b0, 1'b0, 32'h0);
        // capacity above the entry count
        add_capacity(5'd31);
        add_access(lfu_pkg::OP_PUT, 16'h8000, 32'h00008000, 1'b0, 1'b0, 32'h0);
        add_access(lfu_pkg::OP_PUT, 16'h0001, 32'h00000001, 1'b0, 1'b0, 32'h0);
        add_access(lfu_pkg::OP_GET, 16'hFFFF, 32'h0, 1'b0, 1'b0, 32'h0);
        add_capacity(5'd1);
        add_access(lfu_pkg::OP_PUT, 16'h2222, 32'h22222222, 1'b0, 1'b0, 32'h0);
        add_access(lfu_pkg::OP_GET, 16'h2222, 32'h0, 1'b0, 1'b0, 32'h0);
        add_access(lfu_pkg::OP_GET, 16'h0000, 32'h0, 1'b0, 1'b0, 32'h0);

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[n]) begin
            if (script[n].kind == ROW_CAPACITY)
                write_capacity(script[n].cap);
            else
                send_access(script[n].item, script[n].typed, script[n].want);
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            write_capacity(phase_caps[ph]);
            eff_cap = (phase_caps[ph] > ENTRIES) ? ENTRIES : phase_caps[ph];
            win = (eff_cap == 0) ? 8 : eff_cap + 4;
            if (win > KEY_POOL)
                win = KEY_POOL;
            if (ph == PRESSURE_PHASE) begin
                // keep offering while the receiver holds off
                hold_seq   <= hold_seq + 1;
                burst_left = 60;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                item.operation = 1'($urandom_range(0, 1));
                if ($urandom_range(0, 6) == 0)
                    item.key = lfu_pkg::KEY_BITS'($urandom);
                else
                    item.key = key_pool[$urandom_range(0, win - 1)];
                item.value = $urandom;
                send_access(item, 1'b0, none);
            end
        end

        wait_drained();
        if (mismatches == 0 && pending_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
